### src/sfd_pkg.sv
// ============================================================================
// sfd_pkg
// Shared types, constants and helpers of the sum-checked frame deframer.
// ============================================================================
`default_nettype none

package sfd_pkg;

    localparam int unsigned CommandBufferBytes = 20;
    localparam logic [7:0]  SyncByteReset      = 8'hAA;
    localparam logic [7:0]  CmdBufLimit        = 8'(CommandBufferBytes);
    localparam logic [7:0]  BindLen            = 8'd4;
    localparam logic [7:0]  ResetLen           = 8'd5;
    localparam logic [3:0]  TypeRadio          = 4'h1;
    localparam logic [3:0]  TypeNetwork        = 4'h2;
    localparam logic [3:0]  TypeLocal          = 4'h3;
    localparam int unsigned ReplyBit           = 4;

    typedef enum logic [2:0] {
        CLS_ERROR   = 3'd0,
        CLS_RADIO   = 3'd1,
        CLS_NETWORK = 3'd2,
        CLS_LOCAL   = 3'd3,
        CLS_DROPPED = 3'd4
    } t_class;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_BIND  = 2'd1,
        CMD_RESET = 2'd2
    } t_cmd;

    typedef enum logic [4:0] {
        PH_HUNT    = 5'b00001,
        PH_TYPE    = 5'b00010,
        PH_LEN     = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_CHECK   = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       udp_ready;
    } t_in_item;

    // expected byte of "bind" at a payload position, zero past the text
    function automatic logic [7:0] bind_char(input logic [7:0] idx);
        logic [7:0] c;
        case (idx)
            8'd0:    c = 8'h62;
            8'd1:    c = 8'h69;
            8'd2:    c = 8'h6E;
            8'd3:    c = 8'h64;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // expected byte of "reset" at a payload position, zero past the text
    function automatic logic [7:0] reset_char(input logic [7:0] idx);
        logic [7:0] c;
        case (idx)
            8'd0:    c = 8'h72;
            8'd1:    c = 8'h65;
            8'd2:    c = 8'h73;
            8'd3:    c = 8'h65;
            8'd4:    c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### src/sfd_if.sv
// ============================================================================
// sfd_if
// Valid/ready channels of the deframer: byte input, result output, config.
// ============================================================================
`default_nettype none

interface sfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       udp_ready;

    modport source (output valid, output rx_byte, output udp_ready, input ready);
    modport sink   (input valid, input rx_byte, input udp_ready, output ready);
endinterface

interface sfd_out_if;
    logic       valid;
    logic       ready;
    logic       is_verdict;
    logic [7:0] payload_byte;
    logic [2:0] frame_class;
    logic       reply_wanted;
    logic [7:0] frame_length;
    logic [1:0] command;

    modport source (output valid, output is_verdict, output payload_byte,
                    output frame_class, output reply_wanted, output frame_length,
                    output command, input ready);
    modport sink   (input valid, input is_verdict, input payload_byte,
                    input frame_class, input reply_wanted, input frame_length,
                    input command, output ready);
    modport monitor (input valid, input ready, input is_verdict, input payload_byte,
                     input frame_class, input reply_wanted, input frame_length,
                     input command);
endinterface

interface sfd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] sync_byte;

    modport source (output valid, output sync_byte, input ready);
    modport sink   (input valid, input sync_byte, output ready);
endinterface

`default_nettype wire

### src/sfd_in_stage.sv
// ============================================================================
// sfd_in_stage
// Input register: captures one byte transaction per cycle, unless the core holds it.
// ============================================================================
`default_nettype none

module sfd_in_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    sfd_in_if.sink              i_rx,
    input  wire logic           i_adv,
    output sfd_pkg::t_in_item   o_item,
    output logic                o_valid
);

    logic              r_valid;
    sfd_pkg::t_in_item r_item;
    logic              s_take;

    assign i_rx.ready = !r_valid || i_adv;
    assign s_take     = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_take) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_item.rx_byte   <= i_rx.rx_byte;
            r_item.udp_ready <= i_rx.udp_ready;
        end
    end

    assign o_item  = r_item;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

### src/sfd_core.sv
// ============================================================================
// sfd_core
// Frame state, checksum, command match, verdict and result register.
// ============================================================================
`default_nettype none

module sfd_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sfd_pkg::t_in_item  i_item,
    input  wire logic               i_valid,
    output logic                    o_adv,
    sfd_cfg_if.sink                 i_cfg,
    sfd_out_if.source               o_res
);

    logic [7:0]            r_sync;
    sfd_pkg::t_phase       r_phase, n_phase;
    logic [7:0]            r_type, n_type;
    logic [7:0]            r_len, n_len;
    logic [7:0]            r_cnt, n_cnt;
    logic [7:0]            r_sum, n_sum;
    logic                  r_bind, n_bind;
    logic                  r_rst, n_rst;
    logic                  r_ended, n_ended;

    logic                  r_out_valid, n_out_valid;
    logic                  r_is_verdict, n_is_verdict;
    logic [7:0]            r_pb, n_pb;
    sfd_pkg::t_class       r_cls, n_cls;
    logic                  r_reply, n_reply;
    logic [7:0]            r_flen, n_flen;
    sfd_pkg::t_cmd         r_cmd, n_cmd;

    logic                  s_fire;
    logic [7:0]            s_b;
    logic [7:0]            s_cnt_inc;
    logic [3:0]            s_nib;
    logic                  s_rq;

    assign o_adv       = !r_out_valid || o_res.ready;
    assign s_fire      = i_valid && o_adv;
    assign s_b         = i_item.rx_byte;
    assign s_cnt_inc   = r_cnt + 8'd1;
    assign s_nib       = r_type[3:0];
    assign s_rq        = r_type[sfd_pkg::ReplyBit];
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_phase      = r_phase;
        n_type       = r_type;
        n_len        = r_len;
        n_cnt        = r_cnt;
        n_sum        = r_sum;
        n_bind       = r_bind;
        n_rst        = r_rst;
        n_ended      = r_ended;
        n_out_valid  = 1'b0;
        n_is_verdict = 1'b0;
        n_pb         = 8'd0;
        n_cls        = sfd_pkg::CLS_ERROR;
        n_reply      = 1'b0;
        n_flen       = 8'd0;
        n_cmd        = sfd_pkg::CMD_NONE;
        case (r_phase)
            sfd_pkg::PH_HUNT: begin
                if (s_b == r_sync) begin
                    n_phase = sfd_pkg::PH_TYPE;
                end
            end
            sfd_pkg::PH_TYPE: begin
                n_type  = s_b;
                n_phase = sfd_pkg::PH_LEN;
            end
            sfd_pkg::PH_LEN: begin
                n_len   = s_b;
                n_cnt   = 8'd0;
                n_sum   = 8'd0;
                n_bind  = 1'b1;
                n_rst   = 1'b1;
                n_ended = 1'b0;
                n_phase = (s_b == 8'd0) ? sfd_pkg::PH_CHECK : sfd_pkg::PH_PAYLOAD;
            end
            sfd_pkg::PH_PAYLOAD: begin
                n_sum = r_sum + s_b;
                if (!r_ended) begin
                    if (s_b != sfd_pkg::bind_char(r_cnt)) begin
                        n_bind = 1'b0;
                    end
                    if (s_b != sfd_pkg::reset_char(r_cnt)) begin
                        n_rst = 1'b0;
                    end
                    if (s_b == 8'd0) begin
                        n_ended = 1'b1;
                    end
                end
                n_cnt = s_cnt_inc;
                if (s_cnt_inc == r_len) begin
                    n_phase = sfd_pkg::PH_CHECK;
                end
                n_out_valid = 1'b1;
                n_pb        = s_b;
            end
            sfd_pkg::PH_CHECK: begin
                n_phase      = sfd_pkg::PH_HUNT;
                n_out_valid  = 1'b1;
                n_is_verdict = 1'b1;
                n_flen       = r_len;
                if (s_b == r_sum) begin
                    if (s_nib == sfd_pkg::TypeRadio) begin
                        n_cls   = sfd_pkg::CLS_RADIO;
                        n_reply = s_rq;
                    end else if (s_nib == sfd_pkg::TypeNetwork) begin
                        if (i_item.udp_ready) begin
                            n_cls   = sfd_pkg::CLS_NETWORK;
                            n_reply = s_rq;
                        end else begin
                            n_cls = sfd_pkg::CLS_DROPPED;
                        end
                    end else if (s_nib == sfd_pkg::TypeLocal) begin
                        n_cls = sfd_pkg::CLS_LOCAL;
                        if (r_len < sfd_pkg::CmdBufLimit) begin
                            if (r_bind && r_len >= sfd_pkg::BindLen) begin
                                n_cmd = sfd_pkg::CMD_BIND;
                            end else if (r_rst && r_len >= sfd_pkg::ResetLen) begin
                                n_cmd = sfd_pkg::CMD_RESET;
                            end
                        end
                    end
                end
            end
            default: begin
                n_phase = sfd_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync      <= sfd_pkg::SyncByteReset;
            r_phase     <= sfd_pkg::PH_HUNT;
            r_type      <= 8'd0;
            r_len       <= 8'd0;
            r_cnt       <= 8'd0;
            r_sum       <= 8'd0;
            r_bind      <= 1'b1;
            r_rst       <= 1'b1;
            r_ended     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_sync <= i_cfg.sync_byte;
            end
            if (s_fire) begin
                r_phase     <= n_phase;
                r_type      <= n_type;
                r_len       <= n_len;
                r_cnt       <= n_cnt;
                r_sum       <= n_sum;
                r_bind      <= n_bind;
                r_rst       <= n_rst;
                r_ended     <= n_ended;
                r_out_valid <= n_out_valid;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with the transaction that produces it
    always_ff @(posedge i_clk) begin
        if (s_fire && n_out_valid) begin
            r_is_verdict <= n_is_verdict;
            r_pb         <= n_pb;
            r_cls        <= n_cls;
            r_reply      <= n_reply;
            r_flen       <= n_flen;
            r_cmd        <= n_cmd;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.is_verdict   = r_is_verdict;
    assign o_res.payload_byte = r_pb;
    assign o_res.frame_class  = r_cls;
    assign o_res.reply_wanted = r_reply;
    assign o_res.frame_length = r_flen;
    assign o_res.command      = r_cmd;

endmodule

`default_nettype wire

### src/sum_checked_frame_deframer_top.sv
// ============================================================================
// sum_checked_frame_deframer_top
// Byte-serial deframer: sync hunt, header, payload pass-through, checksum
// verdict and local command match.
// ============================================================================
//  channel  | dir | handshake      | payload
//  i_rx     | in  | valid / ready  | rx_byte[7:0], udp_ready
//  o_res    | out | valid / ready  | is_verdict, payload_byte[7:0], frame_class[2:0],
//           |     |                | reply_wanted, frame_length[7:0], command[1:0]
//  i_cfg    | in  | valid / ready  | sync_byte[7:0] (ready always high)
//
//  One byte per cycle unless o_res stalls; results pass the input and result registers.
//  Header and hunt bytes give no result; they only pass the input register and
//  update the core state.
//  A stalled o_res holds the core; the input register absorbs one more byte.
//  Reset is synchronous; no clearing pass.
// ============================================================================
`default_nettype none

module sum_checked_frame_deframer_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sfd_in_if.sink      i_rx,
    sfd_cfg_if.sink     i_cfg,
    sfd_out_if.source   o_res
);

    sfd_pkg::t_in_item s_item;
    logic              s_valid;
    logic              s_adv;

    sfd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_adv   (s_adv),
        .o_item  (s_item),
        .o_valid (s_valid)
    );

    sfd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (s_item),
        .i_valid (s_valid),
        .o_adv   (s_adv),
        .i_cfg   (i_cfg),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

### src/sfd_checker.sv
// ============================================================================
// sfd_checker
// Port-level checks on the deframer result channel.
// ============================================================================
`default_nettype none

module sfd_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic       i_ready,
    input  wire logic       i_is_verdict,
    input  wire logic [7:0] i_payload_byte,
    input  wire logic [2:0] i_frame_class,
    input  wire logic       i_reply_wanted,
    input  wire logic [7:0] i_frame_length,
    input  wire logic [1:0] i_command
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_is_verdict)
            && $stable(i_payload_byte) && $stable(i_frame_class)
            && $stable(i_frame_length) && $stable(i_command)))
        else $error("result changed while stalled");

    a_byte_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_is_verdict) |-> (i_frame_class == sfd_pkg::CLS_ERROR
            && i_frame_length == 8'd0 && i_command == sfd_pkg::CMD_NONE
            && !i_reply_wanted))
        else $error("payload transaction carries verdict fields");

    a_verdict_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_is_verdict) |-> (i_payload_byte == 8'd0
            && i_frame_class <= sfd_pkg::CLS_DROPPED))
        else $error("verdict transaction malformed");

    a_cmd_local: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_command != sfd_pkg::CMD_NONE) |->
            (i_frame_class == sfd_pkg::CLS_LOCAL
            && i_frame_length >= sfd_pkg::BindLen
            && i_frame_length < sfd_pkg::CmdBufLimit))
        else $error("command outside a local frame");

    a_reply_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_reply_wanted) |-> (i_frame_class == sfd_pkg::CLS_RADIO
            || i_frame_class == sfd_pkg::CLS_NETWORK))
        else $error("reply flag on wrong class");

endmodule

bind sum_checked_frame_deframer_top sfd_checker u_sfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_res.valid),
    .i_ready        (o_res.ready),
    .i_is_verdict   (o_res.is_verdict),
    .i_payload_byte (o_res.payload_byte),
    .i_frame_class  (o_res.frame_class),
    .i_reply_wanted (o_res.reply_wanted),
    .i_frame_length (o_res.frame_length),
    .i_command      (o_res.command)
);

`default_nettype wire
